[rtl/core/longest_hex_run_extractor_defines.svh]
// ----------------------------------------------------------------------------
// longest hex run extractor assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef LONGEST_HEX_RUN_EXTRACTOR_DEFINES_SVH
`define LONGEST_HEX_RUN_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define LHRE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LHRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/lhre_pkg.sv]
// ----------------------------------------------------------------------------
// lhre_pkg
// types, constants and helpers shared by the hex run extractor
// ----------------------------------------------------------------------------
package lhre_pkg;

  // parameter defaults
  localparam int TokenMaxDef   = 32;
  localparam int LengthBitsDef = 12;

  // configuration registers
  localparam int              CfgIdxW    = 1;
  localparam logic [CfgIdxW-1:0] CfgMaxCopy = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMinRun  = 1'b1;
  localparam logic [5:0]      MaxCopyRst = 6'd32;
  localparam logic [7:0]      MinRunRst  = 8'd8;

  // character codes
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] CaseDiff = 8'd32;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_window;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic [5:0] token_length;
    logic       found;
    logic       last_char;
  } token_beat_t;

  // scanner to emitter, one pulse per closed window
  typedef struct packed {
    logic start;
    logic found;
    logic bank;
  } emit_ctl_t;

  function automatic logic is_hex(input logic [7:0] b);
    is_hex = (b >= ChDigit0 && b <= ChDigit9) ||
             (b >= ChUpperA && b <= ChUpperF) ||
             (b >= ChLowerA && b <= ChLowerF);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    if (b >= ChLowerA && b <= ChLowerF) begin
      to_upper = b - CaseDiff;
    end else begin
      to_upper = b;
    end
  endfunction

endpackage

[rtl/core/lhre_ram.sv]
// ----------------------------------------------------------------------------
// lhre_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lhre_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    // read data holds while no read is issued
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/lhre_scan.sv]
// ----------------------------------------------------------------------------
// lhre_scan
// input register, run and best tracking, token bank writes
// ----------------------------------------------------------------------------
module lhre_scan #(
  parameter int TokenMax   = lhre_pkg::TokenMaxDef,
  parameter int LengthBits = lhre_pkg::LengthBitsDef,
  localparam int AddrW     = $clog2(2 * TokenMax),
  localparam int IdxW      = $clog2(TokenMax),
  localparam int CntW      = $clog2(TokenMax + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lhre_pkg::rx_beat_t   in_i,
  input  logic [5:0]           max_copy_i,
  input  logic [7:0]           min_run_i,
  input  logic                 emit_busy_i,
  output lhre_pkg::emit_ctl_t  emit_ctl_o,
  output logic [CntW-1:0]      emit_copy_o,
  output logic                 wr_en_o,
  output logic [AddrW-1:0]     wr_addr_o,
  output logic [7:0]           wr_data_o
);

  localparam int CmpW = (LengthBits > 8) ? LengthBits : 8;
  localparam logic [CmpW-1:0] TokCmp = CmpW'(TokenMax);

  logic                  in_valid_q;
  lhre_pkg::rx_beat_t    in_q;
  logic                  proc;
  logic                  hex;
  logic                  closing;
  logic                  beats;
  logic                  found;
  logic [LengthBits-1:0] run_q, run_d, run_inc, run_eff;
  logic [LengthBits-1:0] best_q, best_d, best_c;
  logic                  sel_q, sel_d, sel_c;
  logic [CmpW-1:0]       limit, best_cmp;
  logic [IdxW-1:0]       wr_idx;

  assign proc       = in_valid_q && !emit_busy_i;
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  assign hex     = lhre_pkg::is_hex(in_q.rx_byte);
  assign run_inc = (run_q == '1) ? run_q : run_q + LengthBits'(1);
  assign run_eff = hex ? run_inc : run_q;
  assign closing = !hex || in_q.end_of_window;

  assign beats = closing && (run_eff != '0) && (CmpW'(run_eff) >= CmpW'(min_run_i)) &&
                 (run_eff > best_q);
  assign best_c = beats ? run_eff : best_q;
  assign sel_c  = sel_q ^ beats;

  assign best_cmp = CmpW'(best_c);
  assign found    = (best_c != '0) && (best_cmp >= CmpW'(min_run_i));

  always_comb begin
    if (max_copy_i == '0) begin
      limit = CmpW'(1);
    end else if (CmpW'(max_copy_i) > TokCmp) begin
      limit = TokCmp;
    end else begin
      limit = CmpW'(max_copy_i);
    end
  end

  assign emit_copy_o      = (best_cmp < limit) ? CntW'(best_cmp) : CntW'(limit);
  assign emit_ctl_o.start = proc && in_q.end_of_window;
  assign emit_ctl_o.found = found;
  assign emit_ctl_o.bank  = sel_c;

  always_comb begin
    run_d  = run_q;
    best_d = best_q;
    sel_d  = sel_q;
    if (proc) begin
      sel_d  = sel_c;
      run_d  = closing ? '0 : run_inc;
      best_d = in_q.end_of_window ? '0 : best_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      best_q <= '0;
      sel_q  <= 1'b0;
    end else begin
      run_q  <= run_d;
      best_q <= best_d;
      sel_q  <= sel_d;
    end
  end

  // current run goes to the bank not holding the best token
  assign wr_idx    = IdxW'(run_q);
  assign wr_en_o   = proc && hex && (CmpW'(run_q) < TokCmp);
  assign wr_addr_o = sel_q ? AddrW'(wr_idx) : AddrW'(TokenMax) + AddrW'(wr_idx);
  assign wr_data_o = in_q.rx_byte;

endmodule

[rtl/core/lhre_emit.sv]
// ----------------------------------------------------------------------------
// lhre_emit
// token read sequencer, read data stage and output register
// ----------------------------------------------------------------------------
`include "longest_hex_run_extractor_defines.svh"

module lhre_emit #(
  parameter int TokenMax = lhre_pkg::TokenMaxDef,
  localparam int AddrW   = $clog2(2 * TokenMax),
  localparam int IdxW    = $clog2(TokenMax),
  localparam int CntW    = $clog2(TokenMax + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lhre_pkg::emit_ctl_t   emit_ctl_i,
  input  logic [CntW-1:0]       emit_copy_i,
  output logic                  emit_busy_o,
  output logic                  rd_en_o,
  output logic [AddrW-1:0]      rd_addr_o,
  input  logic [7:0]            rd_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lhre_pkg::token_beat_t out_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } emit_state_e;

  emit_state_e           state_q, state_d;
  logic [CntW-1:0]       idx_q, copy_q;
  logic                  bank_q, found_q;
  logic                  issue, issue_last, out_load;
  logic                  rd_valid_q, rd_found_q, rd_last_q;
  logic [5:0]            rd_len_q;
  logic                  out_valid_q;
  lhre_pkg::token_beat_t out_q;
  logic [IdxW-1:0]       rd_idx;

  assign out_load   = rd_valid_q && (!out_valid_q || out_ready_i);
  assign issue      = (state_q == StRun) && (!rd_valid_q || out_load);
  assign issue_last = (idx_q + CntW'(1)) == copy_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (emit_ctl_i.start) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (issue && issue_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (out_load) begin
        rd_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && emit_ctl_i.start) begin
      idx_q   <= '0;
      bank_q  <= emit_ctl_i.bank;
      found_q <= emit_ctl_i.found;
      // not found is a single beat
      copy_q  <= emit_ctl_i.found ? emit_copy_i : CntW'(1);
    end else if (issue) begin
      idx_q <= idx_q + CntW'(1);
    end
    if (issue) begin
      rd_found_q <= found_q;
      rd_last_q  <= issue_last;
      rd_len_q   <= found_q ? 6'(copy_q) : 6'd0;
    end
    if (out_load) begin
      out_q.token_char   <= rd_found_q ? lhre_pkg::to_upper(rd_data_i) : 8'd0;
      out_q.token_length <= rd_len_q;
      out_q.found        <= rd_found_q;
      out_q.last_char    <= rd_last_q;
    end
  end

  assign rd_idx      = IdxW'(idx_q);
  assign rd_en_o     = issue && found_q;
  assign rd_addr_o   = bank_q ? AddrW'(TokenMax) + AddrW'(rd_idx) : AddrW'(rd_idx);
  assign emit_busy_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `LHRE_ASSERT_NOW(a_start_when_idle, emit_ctl_i.start, state_q == StIdle,
                   "window start while token emission still running")
  `LHRE_ASSERT_NOW(a_read_in_run, rd_en_o, state_q == StRun,
                   "token bank read outside emission")
  `LHRE_ASSERT_NEXT(a_last_issue_ends, issue && issue_last, state_q == StIdle,
                    "emission did not stop after final beat")
  `LHRE_ASSERT_NOW(a_not_found_single, out_valid_q && !out_q.found, out_q.last_char,
                   "not-found beat without last mark")

endmodule

[rtl/core/longest_hex_run_extractor.sv]
// ----------------------------------------------------------------------------
// longest_hex_run_extractor
// finds the longest hex character run of a byte window and emits it
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+------------------------------------
//   in      | in  | in_valid_i/in_ready_o | rx_beat_t: rx_byte, end_of_window
//   out     | out | out_valid_o/out_ready_i | token_beat_t: char, length, found, last
//   cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// ordinary bytes: one beat per cycle while no token emission runs; the input
//   register feeds the run counter and the token bank write
// end of window: copy beats (one when nothing qualifies) leave at one per cycle
//   unless out stalls, paced by the single token bank read port; new bytes wait
//   in the input register until the last read has been issued
// first result beat path: input register, sequencer, bank read, output register
// reset: counters and bank select clear at once, no clearing pass; the token
//   banks are only read where the best run wrote them
// out stalls back up through the read stage and the sequencer to the input register
//
module longest_hex_run_extractor #(
  parameter int TokenMax   = lhre_pkg::TokenMaxDef,
  parameter int LengthBits = lhre_pkg::LengthBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte stream
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lhre_pkg::rx_beat_t            in_i,
  // token stream
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lhre_pkg::token_beat_t         out_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lhre_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  localparam int AddrW = $clog2(2 * TokenMax);
  localparam int CntW  = $clog2(TokenMax + 1);

  logic [5:0]          max_copy_q;
  logic [7:0]          min_run_q;
  lhre_pkg::emit_ctl_t emit_ctl;
  logic [CntW-1:0]     emit_copy;
  logic                emit_busy;
  logic                wr_en, rd_en;
  logic [AddrW-1:0]    wr_addr, rd_addr;
  logic [7:0]          wr_data, rd_data;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_copy_q <= lhre_pkg::MaxCopyRst;
      min_run_q  <= lhre_pkg::MinRunRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lhre_pkg::CfgMaxCopy: max_copy_q <= cfg_data_i[5:0];
        lhre_pkg::CfgMinRun:  min_run_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // run tracking and bank writes
  lhre_scan #(
    .TokenMax   (TokenMax),
    .LengthBits (LengthBits)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .max_copy_i  (max_copy_q),
    .min_run_i   (min_run_q),
    .emit_busy_i (emit_busy),
    .emit_ctl_o  (emit_ctl),
    .emit_copy_o (emit_copy),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // two token banks, bank one at the upper half
  lhre_ram #(
    .Width (8),
    .Depth (2 * TokenMax)
  ) u_banks (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // token read-out
  lhre_emit #(
    .TokenMax (TokenMax)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_ctl_i  (emit_ctl),
    .emit_copy_i (emit_copy),
    .emit_busy_o (emit_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
